// ===== rtl/cctet_pkg.sv =====
// ----------------------------------------------------------------------------
// cctet_pkg: shared types, constants and split tables
// Job record between front and back, geometry bundle, register indexes and
// the two five-tetrahedron corner tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cctet_pkg;

	localparam int IDX_W    = 30;   // linear vertex index width
	localparam int REG_W    = 11;   // geometry register width
	localparam int CELL_W   = 10;   // cell coordinate width
	localparam int SLOT_W   = 3;
	localparam int PLANE_W  = 2 * REG_W;
	localparam int JOBQ_DEPTH = 4;

	localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd4;

	typedef enum logic [1:0] {
		REG_VERTS_X = 2'd0,
		REG_VERTS_Y = 2'd1,
		REG_VERTS_Z = 2'd2
	} cfg_reg_t;

	// geometry derived from the configuration registers
	typedef struct packed {
		logic [REG_W-1:0]   vx;
		logic [REG_W-1:0]   vy;
		logic [REG_W-1:0]   vz;
		logic [PLANE_W-1:0] plane;     // vy*vz
		logic [PLANE_W:0]   plane_vz;  // vy*vz + vz
	} cctet_geom_t;

	// classified cell handed from front to back
	typedef struct packed {
		logic [IDX_W-1:0] base;  // index of corner 0
		logic             odd;   // parity of i+j+k
		logic             err;   // cell outside grid
	} cctet_job_t;

	// corner number (4*l + 2*m + n) of position pos of tetrahedron slot
	function automatic logic [2:0] split_corner(logic odd, logic [SLOT_W-1:0] slot,
			logic [1:0] pos);
		logic [11:0] row;
		logic [2:0]  c;
		if (odd) begin
			case (slot)
				3'd0:    row = {3'd6, 3'd4, 3'd7, 3'd2};
				3'd1:    row = {3'd7, 3'd2, 3'd1, 3'd3};
				3'd2:    row = {3'd1, 3'd4, 3'd7, 3'd5};
				3'd3:    row = {3'd2, 3'd4, 3'd1, 3'd0};
				default: row = {3'd7, 3'd4, 3'd1, 3'd2};
			endcase
		end else begin
			case (slot)
				3'd0:    row = {3'd0, 3'd6, 3'd5, 3'd4};
				3'd1:    row = {3'd3, 3'd6, 3'd0, 3'd2};
				3'd2:    row = {3'd5, 3'd6, 3'd3, 3'd7};
				3'd3:    row = {3'd3, 3'd0, 3'd5, 3'd1};
				default: row = {3'd0, 3'd6, 3'd3, 3'd5};
			endcase
		end
		case (pos)
			2'd0:    c = row[11:9];
			2'd1:    c = row[8:6];
			2'd2:    c = row[5:3];
			default: c = row[2:0];
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cctet_if.sv =====
// ----------------------------------------------------------------------------
// cctet_if: valid/ready channels of the indexer
// Cell channel (input) and tetrahedron channel (output).
// ----------------------------------------------------------------------------
`default_nettype none

interface cctet_cell_if;
	import cctet_pkg::*;

	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_i;
	logic [CELL_W-1:0] cell_j;
	logic [CELL_W-1:0] cell_k;

	modport source (output valid, output cell_i, output cell_j, output cell_k, input ready);
	modport sink   (input valid, input cell_i, input cell_j, input cell_k, output ready);
endinterface

interface cctet_tet_if;
	import cctet_pkg::*;

	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] tet_slot;
	logic [IDX_W-1:0]  corner_a;
	logic [IDX_W-1:0]  corner_b;
	logic [IDX_W-1:0]  corner_c;
	logic [IDX_W-1:0]  corner_d;
	logic              last_of_cell;
	logic              cell_error;

	modport source (output valid, output tet_slot, output corner_a, output corner_b,
		output corner_c, output corner_d, output last_of_cell, output cell_error,
		input ready);
	modport sink   (input valid, input tet_slot, input corner_a, input corner_b,
		input corner_c, input corner_d, input last_of_cell, input cell_error,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/cube_cell_five_tetra_indexer.sv =====
// Flow: an accepted cell passes front stages s1 and s2, the job queue and the
//   back-end job register before its first tetrahedron enters the output register.
// Throughput: the back-end slot sequencer emits one tetrahedron per cycle while
//   tet.ready does not stall it: five per in-grid cell, one per out-of-grid cell.
// Reset: arst_n clears all control state; grid sizes return to 2 x 2 x 2.
// ----------------------------------------------------------------------------
// cube_cell_five_tetra_indexer: split a grid cube cell into five tetrahedra
// Config registers, geometry precompute, front classifier, job queue and
// back-end sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_cell_five_tetra_indexer #(
	parameter int MAX_VERTS_PER_AXIS = 1024
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration write port
	input  wire                          cfg_we,
	input  wire  [1:0]                   cfg_idx,
	input  wire  [cctet_pkg::REG_W-1:0]  cfg_data,
	// channels
	cctet_cell_if.sink                   cube,
	cctet_tet_if.source                  tet
);
	import cctet_pkg::*;

	// clamp limit, wide enough for parameter values up to 8191
	localparam logic [12:0] MAX_V = 13'(MAX_VERTS_PER_AXIS);

	logic [REG_W-1:0]   vx_q, vy_q, vz_q;
	logic [PLANE_W-1:0] plane_q;      // vy*vz, registered from vy_q and vz_q
	logic [PLANE_W:0]   plane_vz_q;   // vy*vz + vz, registered from plane_q and vz_q
	logic [REG_W-1:0]   wr_val;
	cctet_geom_t        geom;

	logic               push;
	cctet_job_t         push_job;
	logic               pop;
	logic               avail;
	cctet_job_t         head;

	// writes above the axis limit saturate to it
	assign wr_val = ({2'b00, cfg_data} > MAX_V) ? MAX_V[REG_W-1:0] : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q       <= 11'd2;
			vy_q       <= 11'd2;
			vz_q       <= 11'd2;
			plane_q    <= 22'd4;
			plane_vz_q <= 23'd6;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_VERTS_X: vx_q <= wr_val;
					REG_VERTS_Y: vy_q <= wr_val;
					REG_VERTS_Z: vz_q <= wr_val;
					default:     ;   // unknown index: write dropped
				endcase
			end
			// Derived geometry follows a write through plane_q and then plane_vz_q; the
			// front pipe reads plane in stage s1 and the back end reads plane_vz, so a
			// cell accepted together with a write can still see the old plane value.
			plane_q    <= vy_q * vz_q;
			plane_vz_q <= {1'b0, plane_q} + (PLANE_W+1)'(vz_q);
		end
	end

	assign geom.vx       = vx_q;
	assign geom.vy       = vy_q;
	assign geom.vz       = vz_q;
	assign geom.plane    = plane_q;
	assign geom.plane_vz = plane_vz_q;

	// front: bounds check, parity, corner-0 index
	cctet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cube     (cube),
		.geom     (geom),
		.pop      (pop),
		.push     (push),
		.push_job (push_job)
	);

	// queue: lets intake run ahead while the back end works through slots
	cctet_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	// back: five tetrahedra per in-grid cell, one per error cell, into the output register
	cctet_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.head   (head),
		.geom   (geom),
		.pop    (pop),
		.tet    (tet)
	);

endmodule

`default_nettype wire

// ===== rtl/cctet_front.sv =====
// ----------------------------------------------------------------------------
// cctet_front: cell intake and classification
// Two-stage pipe: bounds check, parity and row/plane products, then the
// corner-0 index add. Credit counter keeps the job queue from overflowing.
// ----------------------------------------------------------------------------
`default_nettype none

module cctet_front (
	input  wire                     clk,
	input  wire                     arst_n,
	cctet_cell_if.sink              cube,
	input  cctet_pkg::cctet_geom_t  geom,
	input  wire                     pop,
	output logic                    push,
	output cctet_pkg::cctet_job_t   push_job
);
	import cctet_pkg::*;

	logic              accept;
	logic [2:0]        pend_q;   // accepted, not yet taken by the back end

	logic              valid_s1;
	logic [CELL_W-1:0] ci_s1, cj_s1, ck_s1;

	logic              valid_s2;
	logic [IDX_W-1:0]  prod_i_s2;
	logic [20:0]       prod_j_s2;
	logic [CELL_W-1:0] ck_s2;
	logic              odd_s2;
	logic              err_s2;

	logic [31:0]       prod_i;
	logic [20:0]       prod_j;
	logic              in_grid;

	assign cube.ready = (pend_q < 3'(JOBQ_DEPTH));
	assign accept     = cube.valid && cube.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   pend_q <= pend_q + 3'd1;
				2'b01:   pend_q <= pend_q - 3'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	assign prod_i  = ci_s1 * geom.plane;
	assign prod_j  = cj_s1 * geom.vz;
	assign in_grid = ({1'b0, ci_s1} + 11'd1 < geom.vx)
	              && ({1'b0, cj_s1} + 11'd1 < geom.vy)
	              && ({1'b0, ck_s1} + 11'd1 < geom.vz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ci_s1 <= cube.cell_i;
			cj_s1 <= cube.cell_j;
			ck_s1 <= cube.cell_k;
		end
		prod_i_s2 <= prod_i[IDX_W-1:0];
		prod_j_s2 <= prod_j;
		ck_s2     <= ck_s1;
		odd_s2    <= ci_s1[0] ^ cj_s1[0] ^ ck_s1[0];
		err_s2    <= !in_grid;
	end

	assign push          = valid_s2;
	assign push_job.base = prod_i_s2 + IDX_W'(prod_j_s2) + IDX_W'(ck_s2);
	assign push_job.odd  = odd_s2;
	assign push_job.err  = err_s2;

endmodule

`default_nettype wire

// ===== rtl/cctet_jobq.sv =====
// ----------------------------------------------------------------------------
// cctet_jobq: job queue between front and back
// Small register FIFO; the front's credit count guarantees no overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module cctet_jobq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  cctet_pkg::cctet_job_t   push_job,
	input  wire                     pop,
	output logic                    avail,
	output cctet_pkg::cctet_job_t   head
);
	import cctet_pkg::*;

	localparam int PTR_W = $clog2(JOBQ_DEPTH);

	cctet_job_t       entry_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign avail = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

// ===== rtl/cctet_back.sv =====
// ----------------------------------------------------------------------------
// cctet_back: tetrahedron sequencer
// Walks the five slots of a cell (one for an error cell), forms the four
// corner indices per slot and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cctet_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     avail,
	input  cctet_pkg::cctet_job_t   head,
	input  cctet_pkg::cctet_geom_t  geom,
	output logic                    pop,
	cctet_tet_if.source             tet
);
	import cctet_pkg::*;

	logic              busy_q;
	cctet_job_t        job_q;
	logic [SLOT_W-1:0] slot_q;

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [IDX_W-1:0]  out_a_q, out_b_q, out_c_q, out_d_q;
	logic              out_last_q;
	logic              out_err_q;

	logic              out_free;
	logic              last;
	logic              emit;

	function automatic logic [IDX_W-1:0] corner_idx(logic [IDX_W-1:0] base,
			logic [2:0] sel, cctet_geom_t g);
		logic [IDX_W-1:0] off;
		case (sel[2:1])
			2'd0:    off = '0;
			2'd1:    off = IDX_W'(g.vz);
			2'd2:    off = IDX_W'(g.plane);
			default: off = IDX_W'(g.plane_vz);
		endcase
		return base + off + IDX_W'(sel[0]);
	endfunction

	assign out_free = !out_valid_q || tet.ready;
	assign last     = job_q.err || (slot_q == SLOT_LAST);
	assign emit     = busy_q && out_free;
	assign pop      = avail && (!busy_q || (emit && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				slot_q <= '0;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (out_free)
				out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (emit) begin
			out_slot_q <= slot_q;
			out_last_q <= last;
			out_err_q  <= job_q.err;
			if (job_q.err) begin
				out_a_q <= '0;
				out_b_q <= '0;
				out_c_q <= '0;
				out_d_q <= '0;
			end else begin
				out_a_q <= corner_idx(job_q.base, split_corner(job_q.odd, slot_q, 2'd0), geom);
				out_b_q <= corner_idx(job_q.base, split_corner(job_q.odd, slot_q, 2'd1), geom);
				out_c_q <= corner_idx(job_q.base, split_corner(job_q.odd, slot_q, 2'd2), geom);
				out_d_q <= corner_idx(job_q.base, split_corner(job_q.odd, slot_q, 2'd3), geom);
			end
		end
	end

	assign tet.valid        = out_valid_q;
	assign tet.tet_slot     = out_slot_q;
	assign tet.corner_a     = out_a_q;
	assign tet.corner_b     = out_b_q;
	assign tet.corner_c     = out_c_q;
	assign tet.corner_d     = out_d_q;
	assign tet.last_of_cell = out_last_q;
	assign tet.cell_error   = out_err_q;

endmodule

`default_nettype wire
